// ===== rtl/pointwise_conv_weight_fusion_macros.svh =====
// Assertion helpers used by the fusion top level.
`ifndef POINTWISE_CONV_WEIGHT_FUSION_MACROS_SVH
`define POINTWISE_CONV_WEIGHT_FUSION_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PCWF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PCWF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/pcwf_pkg.sv =====
`default_nettype none

package pcwf_pkg;

   localparam int ACC_W     = 40;
   localparam int VAL_W     = 16;
   localparam int PROD_W    = 32;
   localparam int FRAC_BITS = 8;

   localparam logic [1:0] KIND_WEIGHT = 2'd0;
   localparam logic [1:0] KIND_BIAS   = 2'd1;
   localparam logic [1:0] KIND_COLUMN = 2'd2;

   localparam logic signed [ACC_W:0] ROUND_HALF =
      (FRAC_BITS > 0) ? ((ACC_W+1)'(1) << (FRAC_BITS - 1)) : '0;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_EM_READ,
      ST_EM_ADD,
      ST_EM_OUT
   } state_type;

   // Saturating add in the accumulator range.
   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         return s[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

   // Round to nearest (ties up), drop the fraction, clamp to 16 bits.
   function automatic logic signed [VAL_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] a
   );
      logic signed [ACC_W:0] s;
      logic signed [ACC_W:0] q;
      s = {a[ACC_W-1], a} + ROUND_HALF;
      q = s >>> FRAC_BITS;
      if (q > (ACC_W+1)'(32767)) begin
         return 16'sh7fff;
      end else if (q < -(ACC_W+1)'(32768)) begin
         return 16'sh8000;
      end
      return q[VAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pcwf_cell.sv =====
`default_nettype none

// One accumulator of the ring; takes its neighbor's word on each shift.
module pcwf_cell (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  shift,
   input  wire logic signed [pcwf_pkg::ACC_W-1:0]     nbr_acc,
   output logic signed [pcwf_pkg::ACC_W-1:0]          acc_out
);

   logic signed [pcwf_pkg::ACC_W-1:0] acc_ff;
   logic signed [pcwf_pkg::ACC_W-1:0] acc_in;

   always_comb begin
      acc_in = shift ? nbr_acc : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/pointwise_conv_weight_fusion.sv =====
`default_nettype none

// Pointwise convolution weight fusion. Load the down weights (kind 0) and
// down biases (kind 1) first; loads never stall the request port. Then
// stream column elements (kind 2). Each column element does one weight
// memory read per output channel, a registered multiply, and a saturating
// add into the accumulator ring, whose MAX_OUT cells rotate once past the
// single multiply-add unit. An element that ends a column then makes a
// pass of bias read, bias add and rounding per channel, held while the
// result side stalls; this pass also clears the ring. Results arrive as
// rows 0 .. out_channels-1, with out_channels clamped to MAX_OUT and to 16.
// The register port is always ready.
`include "pointwise_conv_weight_fusion_macros.svh"

module pointwise_conv_weight_fusion #(
   parameter int MAX_OUT = 16,
   parameter int MAX_MID = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic [3:0]         req_row,
   input  wire logic [3:0]         req_col,
   input  wire logic signed [15:0] req_value,
   input  wire logic               req_column_end,
   input  wire logic               req_add_down_bias,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_out_row,
   output logic signed [15:0]      rsp_fused_value,
   output logic                    rsp_last_row,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [4:0]         csr_out_channels
);

   localparam int ACC_W   = pcwf_pkg::ACC_W;
   localparam int VAL_W   = pcwf_pkg::VAL_W;
   localparam int CW      = $clog2(MAX_OUT + 1);
   localparam int DEPTH   = MAX_OUT * MAX_MID;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW      = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
   localparam int NW      = (CW > 5) ? CW : 5;
   localparam int OUT_CAP = (MAX_OUT < 16) ? MAX_OUT : 16;

   // storage
   logic signed [VAL_W-1:0] wmem [DEPTH];
   logic signed [VAL_W-1:0] bmem [MAX_OUT];

   pcwf_pkg::state_type state_ff, state_in;

   logic signed [VAL_W-1:0]        x_ff;
   logic                           end_ff;
   logic                           bias_en_ff;
   logic [AW-1:0]                  waddr_ff;
   logic [CW-1:0]                  issue_cnt_ff;
   logic                           rdv_ff;
   logic signed [VAL_W-1:0]        w_rd_ff;
   logic                           pv_ff;
   logic signed [pcwf_pkg::PROD_W-1:0] prod_ff;
   logic [CW-1:0]                  shift_cnt_ff;
   logic [CW-1:0]                  emit_cnt_ff;
   logic signed [VAL_W-1:0]        b_rd_ff;
   logic signed [ACC_W-1:0]        sum_ff;
   logic [4:0]                     out_ch_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [3:0]                     rsp_out_row_ff;
   logic signed [VAL_W-1:0]        rsp_fused_value_ff;
   logic                           rsp_last_row_ff;

   logic                           take;
   logic                           col_ok;
   logic                           row_ok;
   logic                           issue;
   logic                           ring_shift;
   logic                           out_free;
   logic                           emit;
   logic                           emit_live;
   logic                           emit_last;
   logic [NW-1:0]                  n_eff;
   logic signed [ACC_W-1:0]        head;
   logic signed [ACC_W-1:0]        tail_d;
   logic signed [ACC_W-1:0]        bias_term;
   logic signed [ACC_W-1:0]        cell_q [MAX_OUT];

   // accumulator ring: cell 0 is the head, the tail takes the updated word
   for (genvar i = 0; i < MAX_OUT; i++) begin : g_cell
      if (i == MAX_OUT - 1) begin : g_tail
         pcwf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (ring_shift),
            .nbr_acc (tail_d),
            .acc_out (cell_q[i])
         );
      end else begin : g_body
         pcwf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (ring_shift),
            .nbr_acc (cell_q[i+1]),
            .acc_out (cell_q[i])
         );
      end
   end

   assign head = cell_q[0];

   always_comb begin
      col_ok = (32'(req_col) < MAX_MID);
      row_ok = (32'(req_row) < MAX_OUT);
      take   = req_valid && (state_ff == pcwf_pkg::ST_IDLE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcwf_pkg::ST_IDLE: begin
            if (take && req_kind == pcwf_pkg::KIND_COLUMN) begin
               if (col_ok) begin
                  state_in = pcwf_pkg::ST_MAC;
               end else if (req_column_end) begin
                  state_in = pcwf_pkg::ST_EM_READ;
               end
            end
         end
         pcwf_pkg::ST_MAC: begin
            if (pv_ff && shift_cnt_ff == CW'(MAX_OUT - 1)) begin
               state_in = end_ff ? pcwf_pkg::ST_EM_READ : pcwf_pkg::ST_IDLE;
            end
         end
         pcwf_pkg::ST_EM_READ: state_in = pcwf_pkg::ST_EM_ADD;
         pcwf_pkg::ST_EM_ADD:  state_in = pcwf_pkg::ST_EM_OUT;
         pcwf_pkg::ST_EM_OUT: begin
            if (out_free) begin
               state_in = (emit_cnt_ff == CW'(MAX_OUT - 1)) ?
                          pcwf_pkg::ST_IDLE : pcwf_pkg::ST_EM_READ;
            end
         end
         default: state_in = pcwf_pkg::ST_IDLE;
      endcase
   end

   // control and datapath outputs
   always_comb begin
      req_stall  = (state_ff != pcwf_pkg::ST_IDLE);
      issue      = (state_ff == pcwf_pkg::ST_MAC) && (issue_cnt_ff != CW'(MAX_OUT));
      ring_shift = ((state_ff == pcwf_pkg::ST_MAC) && pv_ff) ||
                   (state_ff == pcwf_pkg::ST_EM_ADD);
      // drain the head and refill with zero while emitting
      tail_d     = (state_ff == pcwf_pkg::ST_EM_ADD) ? '0 :
                   pcwf_pkg::sat_add(head, ACC_W'(prod_ff));
      bias_term  = bias_en_ff ? (ACC_W'(b_rd_ff) <<< pcwf_pkg::FRAC_BITS) : '0;
      out_free   = !rsp_valid_ff || !rsp_stall;
      emit       = (state_ff == pcwf_pkg::ST_EM_OUT) && out_free;
      n_eff      = (NW'(out_ch_ff) > NW'(OUT_CAP)) ? NW'(OUT_CAP) : NW'(out_ch_ff);
      emit_live  = NW'(emit_cnt_ff) < n_eff;
      emit_last  = (NW'(emit_cnt_ff) + NW'(1)) == n_eff;
      if (emit && emit_live) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcwf_pkg::ST_IDLE;
         issue_cnt_ff <= '0;
         shift_cnt_ff <= '0;
         emit_cnt_ff  <= '0;
         rdv_ff       <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         out_ch_ff    <= 5'd16;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= issue;
         pv_ff        <= rdv_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            out_ch_ff <= csr_out_channels;
         end
         if (take) begin
            issue_cnt_ff <= '0;
            shift_cnt_ff <= '0;
            emit_cnt_ff  <= '0;
         end else begin
            if (issue) begin
               issue_cnt_ff <= issue_cnt_ff + CW'(1);
            end
            if (state_ff == pcwf_pkg::ST_MAC && pv_ff) begin
               shift_cnt_ff <= shift_cnt_ff + CW'(1);
            end
            if (emit) begin
               emit_cnt_ff <= emit_cnt_ff + CW'(1);
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         x_ff       <= req_value;
         end_ff     <= req_column_end;
         bias_en_ff <= req_add_down_bias;
         waddr_ff   <= AW'(req_col);
      end else if (issue) begin
         waddr_ff <= AW'(32'(waddr_ff) + MAX_MID);
      end
      if (rdv_ff) begin
         prod_ff <= w_rd_ff * x_ff;
      end
      if (state_ff == pcwf_pkg::ST_EM_ADD) begin
         sum_ff <= pcwf_pkg::sat_add(head, bias_term);
      end
      if (emit && emit_live) begin
         rsp_out_row_ff     <= 4'(emit_cnt_ff);
         rsp_fused_value_ff <= pcwf_pkg::round_sat(sum_ff);
         rsp_last_row_ff    <= emit_last;
      end
   end

   // weight memory: write on load, read one row per cycle during a column element
   always_ff @(posedge clock) begin
      if (take && req_kind == pcwf_pkg::KIND_WEIGHT && row_ok && col_ok) begin
         wmem[AW'(32'(req_row) * MAX_MID + 32'(req_col))] <= req_value;
      end
      if (issue) begin
         w_rd_ff <= wmem[waddr_ff];
      end
   end

   // bias memory
   always_ff @(posedge clock) begin
      if (take && req_kind == pcwf_pkg::KIND_BIAS && row_ok) begin
         bmem[BW'(req_row)] <= req_value;
      end
      if (state_ff == pcwf_pkg::ST_EM_READ) begin
         b_rd_ff <= bmem[emit_cnt_ff[BW-1:0]];
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_out_row_ff;
   assign rsp_fused_value = rsp_fused_value_ff;
   assign rsp_last_row    = rsp_last_row_ff;

   `PCWF_ASSERT(a_prod_follows_read, clock, reset, pv_ff |-> $past(rdv_ff), "product without read")
   `PCWF_ASSERT(a_mac_done_all_read, clock, reset, (state_ff == pcwf_pkg::ST_MAC && state_in != pcwf_pkg::ST_MAC) |-> (issue_cnt_ff == CW'(MAX_OUT)), "ring done before all reads")
   `PCWF_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == pcwf_pkg::ST_EM_OUT), "result word outside emission")

endmodule

`default_nettype wire
